[rtl/wpng_pkg.sv]
`default_nettype none

package wpng_pkg;

  localparam int CHANNELS_DEF = 8;

  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 24;
  localparam int SEED_W   = 32;
  localparam int TAP_W    = 32;
  localparam int TAPS     = 8;
  localparam int TAP_IW   = 3;
  localparam int TAP_CW   = TAP_IW + 1;
  localparam int COEF_W   = 18;
  // white as seen by the filter: seed >>> 7, Q1.24
  localparam int WHITE_W  = SEED_W - 7;
  localparam int PM_W     = COEF_W + TAP_W;
  localparam int PN_W     = COEF_W + WHITE_W;
  localparam int ACC_W    = PM_W + 1;
  localparam int COEF_SHIFT = 17;
  localparam int SUM_W    = TAP_W + TAP_IW;

  localparam logic [SEED_W-1:0]        LCG_MULT   = 32'd282475249;
  localparam logic signed [COEF_W-1:0] DELAY_COEF = 18'sd15195;
  localparam logic [TAP_IW-1:0]        LAST_TAP   = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_TAPS,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              vld;
    logic [TAP_IW-1:0] tap;
  } mac_ctl_t;

  function automatic logic signed [COEF_W-1:0] mem_coef(input logic [TAP_IW-1:0] t);
    logic signed [COEF_W-1:0] c;
    case (t)
      3'd0:    c = 18'sd130923;
      3'd1:    c = 18'sd130196;
      3'd2:    c = 18'sd127009;
      3'd3:    c = 18'sd113574;
      3'd4:    c = 18'sd72090;
      3'd5:    c = -18'sd99824;
      3'd6:    c = 18'sd0;
      default: c = 18'sd131071;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] noise_coef(input logic [TAP_IW-1:0] t);
    logic signed [COEF_W-1:0] c;
    case (t)
      3'd0:    c = 18'sd7277;
      3'd1:    c = 18'sd9840;
      3'd2:    c = 18'sd20166;
      3'd3:    c = 18'sd40696;
      3'd4:    c = 18'sd69855;
      3'd5:    c = -18'sd2215;
      3'd6:    c = 18'sd70281;
      default: c = 18'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/wpng_tap_mac.sv]
`default_nettype none

module wpng_tap_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  wpng_pkg::mac_ctl_t                     ctl_i,
  input  logic signed [wpng_pkg::TAP_W-1:0]      tap_i,
  input  logic signed [wpng_pkg::WHITE_W-1:0]    white_i,
  output wpng_pkg::mac_ctl_t                     ctl_o,
  output logic signed [wpng_pkg::TAP_W-1:0]      sum_tap_o,
  output logic signed [wpng_pkg::TAP_W-1:0]      wr_tap_o
);
  import wpng_pkg::*;

  localparam int SH_W = ACC_W - COEF_SHIFT;
  localparam int DL_W = PN_W - COEF_SHIFT;

  mac_ctl_t                 ctl_q;
  logic signed [PM_W-1:0]   pm_q;
  logic signed [PN_W-1:0]   pn_q;
  logic signed [COEF_W-1:0] ncoef;
  logic signed [ACC_W-1:0]  acc;
  logic [SH_W-1:0]          sh;
  logic signed [TAP_W-1:0]  sat_tap;
  logic signed [TAP_W-1:0]  delay_tap;
  logic                     last;

  // last tap has no noise term, so its noise product slot carries white * delay coef
  assign ncoef = (ctl_i.tap == LAST_TAP) ? DELAY_COEF : noise_coef(ctl_i.tap);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pm_q <= mem_coef(ctl_i.tap) * tap_i;
    pn_q <= ncoef * white_i;
  end

  assign last = (ctl_q.tap == LAST_TAP);
  assign acc  = ACC_W'(pm_q) + (last ? ACC_W'(0) : ACC_W'(pn_q));
  assign sh   = acc[ACC_W-1:COEF_SHIFT];

  always_comb begin
    if (&sh[SH_W-1:TAP_W-1] || ~|sh[SH_W-1:TAP_W-1]) begin
      sat_tap = sh[TAP_W-1:0];
    end else if (sh[SH_W-1]) begin
      sat_tap = {1'b1, {(TAP_W-1){1'b0}}};
    end else begin
      sat_tap = {1'b0, {(TAP_W-1){1'b1}}};
    end
  end

  assign delay_tap = {{(TAP_W-DL_W){pn_q[PN_W-1]}}, pn_q[PN_W-1:COEF_SHIFT]};

  assign ctl_o     = ctl_q;
  assign sum_tap_o = sat_tap;
  assign wr_tap_o  = last ? delay_tap : sat_tap;

endmodule

`default_nettype wire

[rtl/white_pink_noise_generator.sv]
`default_nettype none
// Multichannel white / pink noise source.
// Input stream: tdata[2:0] picks the channel, tuser[0] picks the mode (0 white,
// 1 pink). Each in-range word gives one 24-bit Q1.23 sample on the output stream.
// A word naming a channel at or above CHANNELS is accepted and dropped.
// Config channel: a write of cfg_data_i sets the start seed (zero acts as 1),
// reloads every generator and clears every filter tap.
// One word is in work at a time: a new word is taken only once the last result
// has been loaded into the output register. In pink mode the eight taps stream
// through one tap-memory read port and one multiply-add stage.
// State sits in two synchronous memories (seeds, taps); per-channel valid bits
// stand in for their contents after reset or a config write, so no clearing
// pass is needed and input is taken right after reset.
// The output register frees the input side: a new word is accepted while a
// sample waits, and its result holds in the done state until the slot empties.
module white_pink_noise_generator #(
  parameter int CHANNELS = wpng_pkg::CHANNELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [2:0] channel
  input  logic [0:0]                      s_axis_tuser,  // [0] noise_mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [wpng_pkg::SAMPLE_W-1:0]   m_axis_tdata,  // [23:0] noise_sample
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wpng_pkg::SEED_W-1:0]     cfg_data_i
);
  import wpng_pkg::*;

  localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAP_AW    = CH_AW + TAP_IW;
  localparam int TAP_DEPTH = CHANNELS * TAPS;

  state_e                   state_q, state_d;
  logic [CH_AW-1:0]         ch_q;
  logic                     pink_q;
  logic [SEED_W-1:0]        seed_q;
  logic [SEED_W-1:0]        seed_start_q;
  logic [CHANNELS-1:0]      seed_vld_q;
  logic [CHANNELS-1:0]      tap_vld_q;
  logic [TAP_CW-1:0]        iss_q;
  mac_ctl_t                 rd_ctl_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic                     out_valid_q;
  logic [SAMPLE_W-1:0]      out_data_q;

  logic [SEED_W-1:0]        seed_mem [CHANNELS];
  logic [SEED_W-1:0]        seed_rd_q;
  logic [TAP_W-1:0]         tap_mem  [TAP_DEPTH];
  logic [TAP_W-1:0]         tap_rd_q;

  logic                     in_acc;
  logic                     in_range;
  logic [CH_AW-1:0]         in_ch;
  logic [SEED_W-1:0]        seed_cur;
  logic [SEED_W-1:0]        seed_new;
  logic                     seed_we;
  logic                     issue;
  logic [TAP_IW-1:0]        issue_tap;
  logic                     out_load;
  logic                     cfg_acc;
  logic [SAMPLE_W-1:0]      result;
  logic signed [TAP_W-1:0]  tap_cur;
  mac_ctl_t                 mac_ctl;
  logic signed [TAP_W-1:0]  mac_sum_tap;
  logic signed [TAP_W-1:0]  mac_wr_tap;

  assign in_ch    = CH_AW'(s_axis_tdata[CHAN_W-1:0]);
  assign in_range = int'(s_axis_tdata[CHAN_W-1:0]) < CHANNELS;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;

  assign seed_cur = seed_vld_q[ch_q] ? seed_rd_q : seed_start_q;
  assign seed_new = seed_cur * LCG_MULT;
  assign tap_cur  = tap_vld_q[ch_q] ? $signed(tap_rd_q) : '0;

  // white: seed >>> 8; pink: sat24(sum >>> 4)
  always_comb begin
    if (!pink_q) begin
      result = seed_q[SEED_W-1:SEED_W-SAMPLE_W];
    end else if (&sum_q[SUM_W-1:SAMPLE_W+3] || ~|sum_q[SUM_W-1:SAMPLE_W+3]) begin
      result = sum_q[SAMPLE_W+3:4];
    end else if (sum_q[SUM_W-1]) begin
      result = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_range) state_d = ST_SEED;
      end
      ST_SEED: begin
        state_d = pink_q ? ST_TAPS : ST_DONE;
      end
      ST_TAPS: begin
        if (mac_ctl.vld && mac_ctl.tap == LAST_TAP) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cfg_ready_o   = 1'b0;
    seed_we       = 1'b0;
    issue         = 1'b0;
    issue_tap     = iss_q[TAP_IW-1:0];
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cfg_ready_o   = 1'b1;
      end
      ST_SEED: begin
        seed_we   = 1'b1;
        issue     = pink_q;
        issue_tap = '0;
      end
      ST_TAPS: begin
        issue = !iss_q[TAP_CW-1];
      end
      ST_DONE: begin
        out_load = !out_valid_q || m_axis_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seed_start_q <= SEED_W'(1);
      seed_vld_q   <= '0;
      tap_vld_q    <= '0;
      iss_q        <= '0;
      rd_ctl_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_ctl_q.vld <= issue;
      rd_ctl_q.tap <= issue_tap;
      if (state_q == ST_SEED) begin
        iss_q <= TAP_CW'(1);
      end else if (issue) begin
        iss_q <= iss_q + TAP_CW'(1);
      end
      if (cfg_acc) begin
        seed_start_q <= (cfg_data_i == '0) ? SEED_W'(1) : cfg_data_i;
        seed_vld_q   <= '0;
        tap_vld_q    <= '0;
      end else begin
        if (seed_we) seed_vld_q[ch_q] <= 1'b1;
        if (mac_ctl.vld && mac_ctl.tap == LAST_TAP) tap_vld_q[ch_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q   <= in_ch;
      pink_q <= s_axis_tuser[0];
    end
    if (seed_we) seed_q <= seed_new;
    if (state_q == ST_SEED) begin
      sum_q <= '0;
    end else if (mac_ctl.vld) begin
      sum_q <= sum_q + SUM_W'(mac_sum_tap);
    end
    if (out_load) out_data_q <= result;
  end

  // seed memory, read address straight from the input word
  always_ff @(posedge clk_i) begin
    if (seed_we) seed_mem[ch_q] <= seed_new;
    seed_rd_q <= seed_mem[in_ch];
  end

  // tap memory: read and write in the same cycle always hit different taps
  always_ff @(posedge clk_i) begin
    if (mac_ctl.vld) tap_mem[{ch_q, mac_ctl.tap}] <= mac_wr_tap;
    tap_rd_q <= tap_mem[TAP_AW'({ch_q, issue_tap})];
  end

  wpng_tap_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (rd_ctl_q),
    .tap_i     (tap_cur),
    .white_i   ($signed(seed_q[SEED_W-1:SEED_W-WHITE_W])),
    .ctl_o     (mac_ctl),
    .sum_tap_o (mac_sum_tap),
    .wr_tap_o  (mac_wr_tap)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_mac_in_taps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctl.vld |-> state_q == ST_TAPS)
    else $error("tap product outside tap loop");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_range) |=> state_q == ST_SEED)
    else $error("accepted word did not start");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("result not presented");

  a_tap_row_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mac_ctl.vld && mac_ctl.tap == LAST_TAP && !cfg_acc) |=> tap_vld_q[$past(ch_q)])
    else $error("tap row not marked valid");

endmodule

`default_nettype wire

[dv/tb_top.sv]
module tb_top;
  import wpng_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;  // [2:0] channel
  logic [0:0]          s_axis_tuser = '0;  // [0] noise_mode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_axis_tdata;       // [23:0] noise_sample
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [SEED_W-1:0]   cfg_data_i = '0;

  white_pink_noise_generator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  localparam int          NCHAN      = 8;
  localparam int          NTAPS      = 8;
  localparam logic [31:0] GEN_MULT   = 32'd282475249;
  localparam longint      HOLD_COEF  = 15195;
  localparam int          KSHIFT     = 17;
  localparam logic        MODE_WHITE = 1'b0;
  localparam logic        MODE_PINK  = 1'b1;
  localparam longint      S32_MIN    = -64'sd2147483648;
  localparam longint      S32_MAX    = 64'sd2147483647;
  localparam longint      S24_MIN    = -64'sd8388608;
  localparam longint      S24_MAX    = 64'sd8388607;

  // Q1.17 filter coefficients, tap 0 first
  longint mem_k   [NTAPS] = '{130923, 130196, 127009, 113574, 72090, -99824, 0, 131071};
  longint noise_k [NTAPS] = '{7277, 9840, 20166, 40696, 69855, -2215, 70281, 0};

  logic [31:0]        gen_seed [NCHAN];
  logic signed [31:0] tap_mem  [NCHAN][NTAPS];

  logic [SAMPLE_W-1:0] expected_samples [$];
  logic [SAMPLE_W-1:0] want_sample;
  int                  err_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic longint clamp(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  task automatic reload_state(input logic [31:0] v);
    for (int c = 0; c < NCHAN; c++) begin
      gen_seed[c] = (v == 32'd0) ? 32'd1 : v;
      for (int t = 0; t < NTAPS; t++) tap_mem[c][t] = '0;
    end
  endtask

  // steps the generator (pink: also the filter), returns the next sample
  function automatic logic [SAMPLE_W-1:0] predict_noise(input logic [2:0] ch,
                                                        input logic mode);
    longint s, w24, acc, tsum, res, tmp;
    s    = 0;
    w24  = 0;
    acc  = 0;
    tsum = 0;
    res  = 0;
    tmp  = 0;
    gen_seed[ch] = gen_seed[ch] * GEN_MULT;
    s = longint'($signed(gen_seed[ch]));
    if (mode == MODE_WHITE) begin
      res = s >>> 8;
    end else begin
      w24 = s >>> 7;
      for (int t = 0; t < NTAPS; t++) begin
        acc = mem_k[t] * longint'(tap_mem[ch][t]) + noise_k[t] * w24;
        tmp = clamp(acc >>> KSHIFT, S32_MIN, S32_MAX);
        tap_mem[ch][t] = 32'(tmp);
        tsum = tsum + tmp;
      end
      res = clamp(tsum >>> 4, S24_MIN, S24_MAX);
      tmp = clamp((w24 * HOLD_COEF) >>> KSHIFT, S32_MIN, S32_MAX);
      tap_mem[ch][NTAPS-1] = 32'(tmp);
    end
    return res[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        $error("noise_sample: no word expected, actual %0d", $signed(m_axis_tdata));
        err_count++;
      end else begin
        want_sample = expected_samples.pop_front();
        if (m_axis_tdata !== want_sample) begin
          $error("noise_sample: expected %0d, actual %0d",
                 $signed(want_sample), $signed(m_axis_tdata));
          err_count++;
        end
      end
    end
  end

  task automatic send_word(input logic [2:0] ch, input logic mode);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, ch};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_samples = {expected_samples, predict_noise(ch, mode)};
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    // leave margin for the pink path
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] v);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reload_state(v);
  endtask

  task automatic test_reset_seed();
    send_word(3'd0, MODE_WHITE);
    send_word(3'd0, MODE_PINK);
    send_word(3'd0, MODE_PINK);
    send_word(3'd0, MODE_PINK);
    send_word(3'd7, MODE_WHITE);
    send_word(3'd7, MODE_PINK);
    send_word(3'd7, MODE_PINK);
  endtask

  task automatic test_seed_extremes();
    write_seed(32'hFFFF_FFFF);
    send_word(3'd3, MODE_PINK);
    send_word(3'd3, MODE_PINK);
    send_word(3'd5, MODE_WHITE);
    // zero seed must behave as one
    write_seed(32'd0);
    send_word(3'd0, MODE_WHITE);
    send_word(3'd0, MODE_PINK);
    // odd multiplier keeps 0x80000000, so white sits at the negative limit
    write_seed(32'h8000_0000);
    send_word(3'd1, MODE_WHITE);
    send_word(3'd1, MODE_PINK);
    send_word(3'd1, MODE_PINK);
    send_word(3'd6, MODE_PINK);
  endtask

  task automatic test_reload_clears_taps();
    write_seed(32'h1234_5679);
    send_word(3'd2, MODE_PINK);
    send_word(3'd2, MODE_PINK);
    write_seed(32'h1234_5679);
    send_word(3'd2, MODE_PINK);
    send_word(3'd4, MODE_WHITE);
    write_seed(32'd1);
    send_word(3'd4, MODE_PINK);
  endtask

  // bursts on one channel, mostly pink, to build up filter history
  task automatic test_random_bursts(input int n_items);
    int          sent;
    int          len;
    logic [2:0]  ch;
    sent = 0;
    while (sent < n_items) begin
      ch  = 3'($urandom_range(NCHAN - 1));
      len = $urandom_range(24, 1);
      for (int i = 0; i < len && sent < n_items; i++) begin
        send_word(ch, ($urandom_range(99) < 75) ? MODE_PINK : MODE_WHITE);
        sent++;
      end
      if ($urandom_range(3) == 0) begin
        send_word(3'($urandom_range(NCHAN - 1)), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reload_state(32'd1);

    test_reset_seed();
    test_seed_extremes();
    test_reload_clears_taps();

    send_idle_pct = 17;
    recv_idle_pct = 63;
    write_seed($urandom_range(32'hFFFF_FFFF, 1));
    test_random_bursts(550);

    send_idle_pct = 63;
    recv_idle_pct = 17;
    write_seed(32'hFFFF_FFFF);
    test_random_bursts(550);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_seed($urandom_range(32'hFFFF_FFFF, 1));
    test_random_bursts(550);

    drain_results();
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
